// File: design/hex_dump_line_formatter_top_defines.svh
// assertion macros for the checker file
`ifndef HEX_DUMP_LINE_FORMATTER_TOP_DEFINES_SVH
`define HEX_DUMP_LINE_FORMATTER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HDLF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define HDLF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/hdlf_pkg.sv
package hdlf_pkg;

   localparam int LINE_BYTES = 16;
   localparam int HEX_WIDTH  = 2 * LINE_BYTES + LINE_BYTES / 2;
   localparam int CNT_W      = $clog2(LINE_BYTES + 1);
   localparam int COL_W      = $clog2(HEX_WIDTH + 2);
   localparam int IDX_W      = $clog2(LINE_BYTES);
   localparam int PC_W       = 3;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [COL_W-1:0] col_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [PC_W-1:0]  pc_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_of_run;
   } rsp_type;

   // characters
   localparam logic [6:0] CH_SPACE   = 7'h20;
   localparam logic [6:0] CH_DOT     = 7'h2e;
   localparam logic [6:0] CH_DOLLAR  = 7'h24;
   localparam logic [6:0] CH_NEWLINE = 7'h0a;
   localparam logic [6:0] CH_ZERO    = 7'h30;
   localparam logic [6:0] CH_A_LOWER = 7'h61;
   localparam logic [7:0] PRINT_LOW  = 8'd32;
   localparam logic [7:0] PRINT_HIGH = 8'd126;

   // emit codes
   localparam logic [1:0] EMIT_NONE   = 2'd0;
   localparam logic [1:0] EMIT_ALWAYS = 2'd1;
   localparam logic [1:0] EMIT_MARKER = 2'd2;

   // character source codes
   localparam logic [2:0] SEL_HEX_HI  = 3'd0;
   localparam logic [2:0] SEL_HEX_LO  = 3'd1;
   localparam logic [2:0] SEL_SPACE   = 3'd2;
   localparam logic [2:0] SEL_STORE   = 3'd3;
   localparam logic [2:0] SEL_DOLLAR  = 3'd4;
   localparam logic [2:0] SEL_NEWLINE = 3'd5;

   // end-of-run codes
   localparam logic [1:0] LAST_NEVER        = 2'd0;
   localparam logic [1:0] LAST_NO_SEP_FLUSH = 2'd1;
   localparam logic [1:0] LAST_NO_FLUSH     = 2'd2;
   localparam logic [1:0] LAST_ALWAYS       = 2'd3;

   // jump condition codes
   localparam logic [2:0] JMP_NEVER     = 3'd0;
   localparam logic [2:0] JMP_NO_ACCEPT = 3'd1;
   localparam logic [2:0] JMP_NO_SEP    = 3'd2;
   localparam logic [2:0] JMP_PAD_MORE  = 3'd3;
   localparam logic [2:0] JMP_TEXT_MORE = 3'd4;

   // program addresses
   localparam pc_type STEP_WAIT    = 3'd0;
   localparam pc_type STEP_HEX_HI  = 3'd1;
   localparam pc_type STEP_HEX_LO  = 3'd2;
   localparam pc_type STEP_SEP     = 3'd3;
   localparam pc_type STEP_PAD     = 3'd4;
   localparam pc_type STEP_TEXT    = 3'd5;
   localparam pc_type STEP_MARKER  = 3'd6;
   localparam pc_type STEP_NEWLINE = 3'd7;

   typedef struct packed {
      logic [1:0] emit;
      logic [2:0] char_sel;
      logic [1:0] last_sel;
      logic [2:0] jump_sel;
      pc_type     target;
      logic       store_wr;
      logic       count_inc;
      logic       column_inc;
      logic       text_inc;
      logic       line_clear;
   } ctl_type;

   function automatic ctl_type step_rom(pc_type pc);
      ctl_type w;
      w = '0;
      case (pc)
         STEP_WAIT: begin
            w.jump_sel = JMP_NO_ACCEPT;
            w.target   = STEP_WAIT;
         end
         STEP_HEX_HI: begin
            w.emit       = EMIT_ALWAYS;
            w.char_sel   = SEL_HEX_HI;
            w.store_wr   = 1'b1;
            w.count_inc  = 1'b1;
            w.column_inc = 1'b1;
         end
         STEP_HEX_LO: begin
            w.emit       = EMIT_ALWAYS;
            w.char_sel   = SEL_HEX_LO;
            w.last_sel   = LAST_NO_SEP_FLUSH;
            w.jump_sel   = JMP_NO_SEP;
            w.target     = STEP_PAD;
            w.column_inc = 1'b1;
         end
         STEP_SEP: begin
            w.emit       = EMIT_ALWAYS;
            w.char_sel   = SEL_SPACE;
            w.last_sel   = LAST_NO_FLUSH;
            w.column_inc = 1'b1;
         end
         STEP_PAD: begin
            w.emit       = EMIT_ALWAYS;
            w.char_sel   = SEL_SPACE;
            w.jump_sel   = JMP_PAD_MORE;
            w.target     = STEP_PAD;
            w.column_inc = 1'b1;
         end
         STEP_TEXT: begin
            w.emit     = EMIT_ALWAYS;
            w.char_sel = SEL_STORE;
            w.jump_sel = JMP_TEXT_MORE;
            w.target   = STEP_TEXT;
            w.text_inc = 1'b1;
         end
         STEP_MARKER: begin
            w.emit     = EMIT_MARKER;
            w.char_sel = SEL_DOLLAR;
         end
         STEP_NEWLINE: begin
            w.emit       = EMIT_ALWAYS;
            w.char_sel   = SEL_NEWLINE;
            w.last_sel   = LAST_ALWAYS;
            w.line_clear = 1'b1;
         end
         default: begin
            w.jump_sel = JMP_NO_ACCEPT;
            w.target   = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

   function automatic logic [6:0] hex_char(logic [3:0] nib);
      logic [6:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {3'b000, nib};
      end else begin
         c = CH_A_LOWER + {3'b000, nib} - 7'd10;
      end
      return c;
   endfunction

endpackage

// File: design/hex_dump_line_formatter_top.sv
// hex dump line formatter, 16 bytes per line
// req channel: one beat per raw byte (data_byte, end_of_buffer), valid/ready
// rsp channel: one beat per text character (out_char, last_of_run), valid/ready
// csr port: csr_wr_en writes csr_wr_data into the end marker enable ('$' before newline)
// each byte gives two hex digits, a space after every second byte of a line,
// and on a full line or end_of_buffer the padded hex column, a space, the
// printable text of the line, the optional '$' and a newline
// control is an 8-step microprogram; one step per cycle, at most one character per step
// req_ready is high only while the sequencer waits at its first step, so one
// byte is in work at a time
// the accepted byte is registered, then the high digit step writes its first
// character into the output register once that register has room
// per byte the steps are wait, high digit, low digit and, if a space follows, separator;
// a line flush adds a step per pad, gap, text and newline character, and the marker step
// the output register decouples the sides; when rsp_ready is low the sequencer
// holds on its current step until the register frees up
// reset (synchronous, active high) clears the line counters, the sequencer,
// the output valid and the marker enable; the line text store needs no reset
module hex_dump_line_formatter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hdlf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hdlf_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   // sequencer and line state
   hdlf_pkg::pc_type  pc_ff, pc_in;
   hdlf_pkg::cnt_type cnt_ff, cnt_in;
   hdlf_pkg::col_type col_ff, col_in;
   hdlf_pkg::idx_type rd_ff, rd_in;
   logic [7:0]        byte_ff, byte_in;
   logic              eob_ff, eob_in;
   logic              marker_ff, marker_in;

   // printable text of the current line
   logic [6:0]        store_ff [hdlf_pkg::LINE_BYTES];
   logic [6:0]        store_in;
   logic              store_we;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   hdlf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   hdlf_pkg::ctl_type ctl;
   hdlf_pkg::cnt_type rd_next;
   logic              req_fire;
   logic              sep;
   logic              flush;
   logic              emit_now;
   logic              last_now;
   logic              jump_taken;
   logic              slot_free;
   logic              advance;
   logic [6:0]        char_now;

   // current control word
   assign ctl = hdlf_pkg::step_rom(pc_ff);

   assign req_ready = (pc_ff == hdlf_pkg::STEP_WAIT);
   assign req_fire  = req_valid && req_ready;

   // count already holds this byte once past the high digit step
   assign sep     = !cnt_ff[0] && (cnt_ff < hdlf_pkg::cnt_type'(hdlf_pkg::LINE_BYTES));
   assign flush   = (cnt_ff == hdlf_pkg::cnt_type'(hdlf_pkg::LINE_BYTES)) || eob_ff;
   assign rd_next = hdlf_pkg::cnt_type'(rd_ff) + hdlf_pkg::cnt_type'(1);

   always_comb begin
      case (ctl.emit)
         hdlf_pkg::EMIT_NONE:   emit_now = 1'b0;
         hdlf_pkg::EMIT_ALWAYS: emit_now = 1'b1;
         hdlf_pkg::EMIT_MARKER: emit_now = marker_ff;
         default:               emit_now = 1'b0;
      endcase
   end

   always_comb begin
      case (ctl.char_sel)
         hdlf_pkg::SEL_HEX_HI:  char_now = hdlf_pkg::hex_char(byte_ff[7:4]);
         hdlf_pkg::SEL_HEX_LO:  char_now = hdlf_pkg::hex_char(byte_ff[3:0]);
         hdlf_pkg::SEL_SPACE:   char_now = hdlf_pkg::CH_SPACE;
         hdlf_pkg::SEL_STORE:   char_now = store_ff[rd_ff];
         hdlf_pkg::SEL_DOLLAR:  char_now = hdlf_pkg::CH_DOLLAR;
         hdlf_pkg::SEL_NEWLINE: char_now = hdlf_pkg::CH_NEWLINE;
         default:               char_now = hdlf_pkg::CH_SPACE;
      endcase
   end

   always_comb begin
      case (ctl.last_sel)
         hdlf_pkg::LAST_NEVER:        last_now = 1'b0;
         hdlf_pkg::LAST_NO_SEP_FLUSH: last_now = !sep && !flush;
         hdlf_pkg::LAST_NO_FLUSH:     last_now = !flush;
         hdlf_pkg::LAST_ALWAYS:       last_now = 1'b1;
         default:                     last_now = 1'b0;
      endcase
   end

   always_comb begin
      case (ctl.jump_sel)
         hdlf_pkg::JMP_NEVER:     jump_taken = 1'b0;
         hdlf_pkg::JMP_NO_ACCEPT: jump_taken = !req_fire;
         hdlf_pkg::JMP_NO_SEP:    jump_taken = !sep;
         // pad spaces plus the one gap space
         hdlf_pkg::JMP_PAD_MORE:  jump_taken = col_ff < hdlf_pkg::col_type'(hdlf_pkg::HEX_WIDTH);
         hdlf_pkg::JMP_TEXT_MORE: jump_taken = rd_next < cnt_ff;
         default:                 jump_taken = 1'b0;
      endcase
   end

   // a step that emits waits for room in the output register
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign advance   = !emit_now || slot_free;

   always_comb begin
      pc_in = pc_ff;
      if (advance) begin
         if (emit_now && last_now) begin
            pc_in = hdlf_pkg::STEP_WAIT;
         end else if (jump_taken) begin
            pc_in = ctl.target;
         end else begin
            pc_in = pc_ff + hdlf_pkg::pc_type'(1);
         end
      end
   end

   // datapath
   always_comb begin
      byte_in   = byte_ff;
      eob_in    = eob_ff;
      cnt_in    = cnt_ff;
      col_in    = col_ff;
      rd_in     = rd_ff;
      marker_in = marker_ff;
      store_we  = 1'b0;
      if ((byte_ff >= hdlf_pkg::PRINT_LOW) && (byte_ff <= hdlf_pkg::PRINT_HIGH)) begin
         store_in = byte_ff[6:0];
      end else begin
         store_in = hdlf_pkg::CH_DOT;
      end
      if (req_fire) begin
         byte_in = req_data.data_byte;
         eob_in  = req_data.end_of_buffer;
      end
      if (advance) begin
         store_we = ctl.store_wr;
         if (ctl.count_inc) begin
            cnt_in = cnt_ff + hdlf_pkg::cnt_type'(1);
         end
         if (ctl.column_inc) begin
            col_in = col_ff + hdlf_pkg::col_type'(1);
         end
         if (ctl.text_inc) begin
            rd_in = rd_ff + hdlf_pkg::idx_type'(1);
         end
         if (ctl.line_clear) begin
            cnt_in = '0;
            col_in = '0;
            rd_in  = '0;
         end
      end
      if (csr_wr_en) begin
         marker_in = csr_wr_data;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && emit_now) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_char    = char_now;
         rsp_data_in.last_of_run = last_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= hdlf_pkg::STEP_WAIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         rd_ff        <= '0;
         eob_ff       <= 1'b0;
         marker_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         rd_ff        <= rd_in;
         eob_ff       <= eob_in;
         marker_ff    <= marker_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
      if (store_we) begin
         store_ff[cnt_ff[hdlf_pkg::IDX_W-1:0]] <= store_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/hdlf_checker.sv
`include "hex_dump_line_formatter_top_defines.svh"

module hdlf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hdlf_pkg::rsp_type rsp_data
);

   // a waiting result beat stays
   `HDLF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")

   // and keeps its payload
   `HDLF_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp payload moved")

   // one byte at a time: no back-to-back request beats
   `HDLF_ASSERT_NEXT(a_req_single, req_valid && req_ready, !req_ready, "request taken twice")

   // no new byte while a run is still being delivered
   `HDLF_ASSERT_NOW(a_run_open, rsp_valid && !rsp_data.last_of_run, !req_ready,
                    "request taken mid run")

endmodule

bind hex_dump_line_formatter_top hdlf_checker u_hdlf_checker (.*);
